[hw/rtl/xcr_pkg.sv]
// Shared types and constants for the XMODEM-CRC receiver.
`default_nettype none

package xcr_pkg;

  localparam int unsigned RESULTS_MAX = 6;
  localparam int unsigned RES_CNT_W   = $clog2(RESULTS_MAX + 1);
  localparam int unsigned RES_IDX_W   = $clog2(RESULTS_MAX);
  localparam int unsigned BLOCK_BYTES = 128;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_READY = 8'h43;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STARTED  = 3'd1,
    EV_CANCELED = 3'd2,
    EV_COMMIT   = 3'd3,
    EV_COMPLETE = 3'd4
  } xcr_event_t;

  typedef enum logic [1:0] {
    CFG_READY_INTERVAL   = 2'd0,
    CFG_SESSION_TIMEOUT  = 2'd1,
    CFG_BYTE_TIMEOUT     = 2'd2,
    CFG_CANCEL_THRESHOLD = 2'd3
  } xcr_cfg_idx_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } xcr_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    xcr_event_t event_code;
    logic       last;
  } xcr_out_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      n;
    xcr_out_t [RESULTS_MAX-1:0] items;
  } xcr_list_t;

endpackage

`default_nettype wire

[hw/rtl/xcr_core.sv]
// Protocol state, configuration registers and per-beat result list builder.
`default_nettype none

module xcr_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire xcr_pkg::xcr_in_t     in_data,
  input  wire logic                 cfg_fire,
  input  wire xcr_pkg::xcr_cfg_idx_t cfg_index,
  input  wire logic [15:0]          cfg_data,
  output xcr_pkg::xcr_list_t        list
);
  import xcr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NUMBER = 3'd1,
    PH_COMPL  = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5
  } phase_t;

  typedef struct packed {
    logic        downloading;
    phase_t      phase;
    logic [7:0]  byte_count;
    logic [7:0]  block_number;
    logic [7:0]  block_complement;
    logic [15:0] received_check;
    logic [15:0] running_check;
    logic [7:0]  expected_block;
    logic [3:0]  cancel_count;
    logic [15:0] session_ticks;
    logic [15:0] byte_ticks;
    logic        byte_timer_on;
  } state_t;

  logic [15:0] ready_interval;
  logic [15:0] session_timeout;
  logic [15:0] byte_timeout;
  logic [3:0]  cancel_threshold;

  state_t    st;
  state_t    st_next;
  xcr_list_t lst;
  logic      ended;

  function automatic state_t clear_frame(state_t s);
    state_t r;
    r = s;
    r.phase            = PH_IDLE;
    r.byte_count       = '0;
    r.block_number     = '0;
    r.block_complement = '0;
    r.received_check   = '0;
    r.running_check    = '0;
    r.byte_ticks       = '0;
    r.byte_timer_on    = 1'b0;
    return r;
  endfunction

  function automatic state_t end_session(state_t s);
    state_t r;
    r = clear_frame(s);
    r.downloading    = 1'b0;
    r.expected_block = 8'd1;
    r.cancel_count   = '0;
    r.session_ticks  = '0;
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ 16'h1021;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic xcr_list_t push_res(xcr_list_t l, xcr_out_t r);
    xcr_list_t o;
    o = l;
    if (l.n < RES_CNT_W'(RESULTS_MAX)) begin
      o.items[l.n[RES_IDX_W-1:0]] = r;
      o.n = l.n + RES_CNT_W'(1);
    end
    return o;
  endfunction

  function automatic xcr_out_t tx_res(logic [7:0] b);
    xcr_out_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  function automatic xcr_out_t ev_res(xcr_event_t e);
    xcr_out_t r;
    r = '0;
    r.event_code = e;
    return r;
  endfunction

  function automatic xcr_out_t data_res(logic [7:0] b, logic [6:0] idx);
    xcr_out_t r;
    r = '0;
    r.data_valid = 1'b1;
    r.data_byte  = b;
    r.data_index = idx;
    return r;
  endfunction

  always_comb begin
    st_next = st;
    lst     = '0;
    ended   = 1'b0;
    if (in_data.operation) begin
      if (st.session_ticks != 16'hFFFF) begin
        st_next.session_ticks = st.session_ticks + 16'd1;
      end
      if (st.byte_timer_on) begin
        if (st.byte_ticks != 16'hFFFF) begin
          st_next.byte_ticks = st.byte_ticks + 16'd1;
        end
        if (st_next.byte_ticks > byte_timeout) begin
          st_next = clear_frame(st_next);
          lst = push_res(lst, tx_res(CH_NAK));
        end
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: begin
          priority if (in_data.rx_byte == CH_SOH) begin
            st_next.cancel_count = '0;
            st_next.phase        = PH_NUMBER;
            if (!st.downloading) begin
              st_next.downloading   = 1'b1;
              st_next.session_ticks = '0;
              lst = push_res(lst, ev_res(EV_STARTED));
            end
            st_next.byte_ticks    = '0;
            st_next.byte_timer_on = 1'b1;
          end else if (in_data.rx_byte == CH_CAN) begin
            st_next.cancel_count = st.cancel_count + 4'd1;
            if (st_next.cancel_count >= cancel_threshold) begin
              st_next.cancel_count = '0;
              if (st.downloading) begin
                lst = push_res(lst, ev_res(EV_CANCELED));
                st_next = end_session(st_next);
                ended = 1'b1;
              end
            end
          end else if (in_data.rx_byte == CH_EOT) begin
            lst = push_res(lst, tx_res(CH_ACK));
            lst = push_res(lst, ev_res(EV_COMPLETE));
            st_next = end_session(st_next);
            ended = 1'b1;
          end else begin
            st_next.cancel_count = '0;
          end
        end
        PH_NUMBER: begin
          st_next.block_number = in_data.rx_byte;
          st_next.phase        = PH_COMPL;
          st_next.byte_ticks   = '0;
        end
        PH_COMPL: begin
          st_next.block_complement = in_data.rx_byte;
          st_next.phase            = PH_DATA;
          st_next.byte_ticks       = '0;
        end
        PH_DATA: begin
          if (st.byte_count < 8'(BLOCK_BYTES)) begin
            lst = push_res(lst, data_res(in_data.rx_byte, st.byte_count[6:0]));
            st_next.running_check = crc_byte(st.running_check, in_data.rx_byte);
            st_next.byte_count    = st.byte_count + 8'd1;
          end
          if (st_next.byte_count >= 8'(BLOCK_BYTES)) begin
            st_next.phase = PH_CRC_HI;
          end
          st_next.byte_ticks = '0;
        end
        PH_CRC_HI: begin
          st_next.received_check = {in_data.rx_byte, 8'h00};
          st_next.phase          = PH_CRC_LO;
          st_next.byte_ticks     = '0;
        end
        PH_CRC_LO: begin
          if ((8'(st.block_number + st.block_complement) == 8'hFF)
              && (st.running_check == {st.received_check[15:8], in_data.rx_byte})) begin
            if (st.block_number == st.expected_block) begin
              st_next.expected_block = st.expected_block + 8'd1;
              lst = push_res(lst, tx_res(CH_ACK));
              lst = push_res(lst, ev_res(EV_COMMIT));
            end else if (st.block_number == st.expected_block - 8'd1) begin
              lst = push_res(lst, tx_res(CH_ACK));
            end else begin
              lst = push_res(lst, tx_res(CH_NAK));
            end
          end else begin
            lst = push_res(lst, tx_res(CH_NAK));
          end
          st_next = clear_frame(st_next);
          st_next.session_ticks = '0;
        end
        default: begin
          st_next = clear_frame(st_next);
        end
      endcase
    end

    if (!ended) begin
      if (st_next.downloading) begin
        if (st_next.session_ticks >= session_timeout) begin
          lst = push_res(lst, tx_res(CH_CAN));
          lst = push_res(lst, tx_res(CH_CAN));
          lst = push_res(lst, tx_res(CH_CAN));
          lst = push_res(lst, tx_res(CH_CAN));
          lst = push_res(lst, tx_res(CH_SUB));
          st_next = end_session(st_next);
        end
      end else if (st_next.session_ticks >= ready_interval) begin
        st_next.session_ticks = '0;
        lst = push_res(lst, tx_res(CH_READY));
      end
    end

    if (lst.n != '0) begin
      lst.items[RES_IDX_W'(lst.n - RES_CNT_W'(1))].last = 1'b1;
    end
  end

  assign list = lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= end_session('0);
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_interval   <= 16'd100;
      session_timeout  <= 16'd1000;
      byte_timeout     <= 16'd300;
      cancel_threshold <= 4'd2;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_READY_INTERVAL:   ready_interval   <= cfg_data;
        CFG_SESSION_TIMEOUT:  session_timeout  <= cfg_data;
        CFG_BYTE_TIMEOUT:     byte_timeout     <= cfg_data;
        CFG_CANCEL_THRESHOLD: cancel_threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/xcr_out_queue.sv]
// Result register that holds one step's result list and sends it a beat at a time.
`default_nettype none

module xcr_out_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire xcr_pkg::xcr_list_t list,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output xcr_pkg::xcr_out_t       out_data
);
  import xcr_pkg::*;

  xcr_out_t [RESULTS_MAX-1:0] items;
  logic [RES_CNT_W-1:0]       count;
  logic [RES_IDX_W-1:0]       ptr;
  logic                       final_beat;

  assign out_valid  = (count != '0);
  assign out_data   = items[ptr];
  assign final_beat = out_valid && out_ready
                      && (RES_CNT_W'(ptr) == count - RES_CNT_W'(1));
  assign can_load   = !out_valid || final_beat;

  always_ff @(posedge clk) begin
    if (load) begin
      items <= list.items;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else if (load) begin
      count <= list.n;
      ptr   <= '0;
    end else if (final_beat) begin
      count <= '0;
      ptr   <= '0;
    end else if (out_valid && out_ready) begin
      ptr <= ptr + RES_IDX_W'(1);
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (RES_CNT_W'(ptr) < count))
    else $error("result pointer past list end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RESULTS_MAX))
    else $error("result count too large");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (RES_CNT_W'(ptr) == count - RES_CNT_W'(1))))
    else $error("last flag not on final beat of the list");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && (list.n != '0)) |=> out_valid)
    else $error("loaded list not presented");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("list loaded over pending results");

endmodule

`default_nettype wire

[hw/rtl/xmodem_crc_receiver.sv]
// Top level of the XMODEM-CRC receiver: input, config and result channels.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat is either a received serial
//     byte (operation 0) or one 10 ms timer tick (operation 1).
//   out channel (out_valid/out_ready/out_data): zero to six result beats per input
//     beat, in order; the final one of an input carries last. A beat is a byte to
//     send back, a payload byte with its index, or an event code.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only
//     while idle.
// Latency: the first result of an input appears the cycle after it is taken.
// Throughput: one input beat per cycle while each input yields at most one result
//   and out_ready is high; an input with more results holds in_ready low while the
//   single output register drains them, one beat per cycle while out_ready is high.
// Reset: session waiting, expected block 1, registers back to their defaults,
//   result register empty.
// Receiver stall: results hold in the output register; in_ready drops only once a
//   pending list cannot be replaced on its final beat.
`default_nettype none

module xmodem_crc_receiver (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire xcr_pkg::xcr_in_t      in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output xcr_pkg::xcr_out_t          out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire xcr_pkg::xcr_cfg_idx_t cfg_index,
  input  wire logic [15:0]           cfg_data
);
  import xcr_pkg::*;

  xcr_list_t list;
  logic      in_fire;
  logic      can_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign in_fire   = in_valid && can_load;

  xcr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .list      (list)
  );

  xcr_out_queue u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .list      (list),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/sv/xcr_response_checker.sv]
// Response checker for the XMODEM-CRC receiver: predicts and compares every result beat.
package xcr_tb_pkg;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
    end
    return crc;
  endfunction

endpackage

module xcr_response_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  xcr_pkg::xcr_in_t      in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  xcr_pkg::xcr_out_t     out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  xcr_pkg::xcr_cfg_idx_t cfg_index,
  input  logic [15:0]           cfg_data,
  output int                    mismatches,
  output int                    replies_pending,
  output int                    replies_seen
);
  import xcr_pkg::*;
  import xcr_tb_pkg::*;

  typedef enum logic [2:0] {
    FR_IDLE    = 3'd0,
    FR_NUMBER  = 3'd1,
    FR_COMPL   = 3'd2,
    FR_DATA    = 3'd3,
    FR_CRC_HI  = 3'd4,
    FR_CRC_LO  = 3'd5
  } frame_phase_t;

  logic [15:0]  ready_ivl, sess_limit, gap_limit;
  logic [3:0]   can_limit;

  logic         downloading;
  frame_phase_t phase;
  logic [7:0]   count, blk_num, blk_cmp, want_blk;
  logic [15:0]  rx_crc, run_crc, sess_ticks, gap_ticks;
  logic [3:0]   can_cnt;
  logic         timer_on;

  xcr_out_t     step_replies[$];
  xcr_out_t     replies_due[$];
  int           errors = 0;
  int           seen = 0;

  function automatic void clear_frame();
    phase     = FR_IDLE;
    count     = '0;
    blk_num   = '0;
    blk_cmp   = '0;
    rx_crc    = '0;
    run_crc   = '0;
    gap_ticks = '0;
    timer_on  = 1'b0;
  endfunction

  function automatic void end_session();
    clear_frame();
    downloading = 1'b0;
    want_blk    = 8'd1;
    can_cnt     = '0;
    sess_ticks  = '0;
  endfunction

  function automatic void add_reply(logic tv, logic [7:0] txb, logic dv, logic [7:0] db,
                                    logic [6:0] di, xcr_event_t ev);
    xcr_out_t r;
    r.tx_valid   = tv;
    r.tx_byte    = txb;
    r.data_valid = dv;
    r.data_byte  = db;
    r.data_index = di;
    r.event_code = ev;
    r.last       = 1'b0;
    if (step_replies.size() < RESULTS_MAX) step_replies.push_back(r);
  endfunction

  task automatic predict_replies(xcr_in_t beat);
    logic       ended;
    logic       hdr_ok;
    logic       crc_ok;
    logic [7:0] b;
    logic [7:0] prev_blk;
    xcr_out_t   r;
    ended = 1'b0;
    b = beat.rx_byte;
    step_replies.delete();
    if (beat.operation) begin
      if (sess_ticks != 16'hFFFF) sess_ticks++;
      if (timer_on) begin
        if (gap_ticks != 16'hFFFF) gap_ticks++;
        if (gap_ticks > gap_limit) begin
          clear_frame();
          add_reply(1'b1, CH_NAK, 1'b0, 8'h00, 7'h00, EV_NONE);
        end
      end
    end else begin
      case (phase)
        FR_IDLE: begin
          if (b == CH_SOH) begin
            can_cnt = '0;
            phase = FR_NUMBER;
            if (!downloading) begin
              downloading = 1'b1;
              sess_ticks = '0;
              add_reply(1'b0, 8'h00, 1'b0, 8'h00, 7'h00, EV_STARTED);
            end
            gap_ticks = '0;
            timer_on = 1'b1;
          end else if (b == CH_CAN) begin
            can_cnt = can_cnt + 4'd1;
            if (can_cnt >= can_limit) begin
              can_cnt = '0;
              if (downloading) begin
                add_reply(1'b0, 8'h00, 1'b0, 8'h00, 7'h00, EV_CANCELED);
                end_session();
                ended = 1'b1;
              end
            end
          end else if (b == CH_EOT) begin
            add_reply(1'b1, CH_ACK, 1'b0, 8'h00, 7'h00, EV_NONE);
            add_reply(1'b0, 8'h00, 1'b0, 8'h00, 7'h00, EV_COMPLETE);
            end_session();
            ended = 1'b1;
          end else begin
            can_cnt = '0;
          end
        end
        FR_NUMBER: begin
          blk_num = b;
          phase = FR_COMPL;
          gap_ticks = '0;
        end
        FR_COMPL: begin
          blk_cmp = b;
          phase = FR_DATA;
          gap_ticks = '0;
        end
        FR_DATA: begin
          if (count < BLOCK_BYTES) begin
            add_reply(1'b0, 8'h00, 1'b1, b, count[6:0], EV_NONE);
            run_crc = crc16_step(run_crc, b);
            count++;
          end
          if (count >= BLOCK_BYTES) phase = FR_CRC_HI;
          gap_ticks = '0;
        end
        FR_CRC_HI: begin
          rx_crc = {b, 8'h00};
          phase = FR_CRC_LO;
          gap_ticks = '0;
        end
        FR_CRC_LO: begin
          rx_crc = {rx_crc[15:8], b};
          hdr_ok = ({1'b0, blk_num} + {1'b0, blk_cmp}) == 9'h0FF;
          crc_ok = run_crc == rx_crc;
          prev_blk = want_blk - 8'd1;
          if (hdr_ok && blk_num == want_blk && crc_ok) begin
            want_blk = want_blk + 8'd1;
            add_reply(1'b1, CH_ACK, 1'b0, 8'h00, 7'h00, EV_NONE);
            add_reply(1'b0, 8'h00, 1'b0, 8'h00, 7'h00, EV_COMMIT);
          end else if (hdr_ok && blk_num == prev_blk && crc_ok) begin
            add_reply(1'b1, CH_ACK, 1'b0, 8'h00, 7'h00, EV_NONE);
          end else begin
            add_reply(1'b1, CH_NAK, 1'b0, 8'h00, 7'h00, EV_NONE);
          end
          clear_frame();
          sess_ticks = '0;
        end
        default: begin
          clear_frame();
        end
      endcase
    end

    if (!ended) begin
      if (downloading) begin
        if (sess_ticks >= sess_limit) begin
          repeat (4) add_reply(1'b1, CH_CAN, 1'b0, 8'h00, 7'h00, EV_NONE);
          add_reply(1'b1, CH_SUB, 1'b0, 8'h00, 7'h00, EV_NONE);
          end_session();
        end
      end else if (sess_ticks >= ready_ivl) begin
        sess_ticks = '0;
        add_reply(1'b1, CH_READY, 1'b0, 8'h00, 7'h00, EV_NONE);
      end
    end

    if (step_replies.size() > 0) step_replies[step_replies.size() - 1].last = 1'b1;
    foreach (step_replies[i]) begin
      r = step_replies[i];
      replies_due.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_reply(xcr_out_t got);
    xcr_out_t want;
    if (replies_due.size() == 0) begin
      $error("result beat 0x%0h arrived with nothing expected", got);
      errors++;
    end else begin
      want = replies_due.pop_front();
      seen++;
      check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("data_index", 8'(want.data_index), 8'(got.data_index));
      check_field("event_code", 8'(want.event_code), 8'(got.event_code));
      check_field("last", 8'(want.last), 8'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ready_ivl  = 16'd100;
      sess_limit = 16'd1000;
      gap_limit  = 16'd300;
      can_limit  = 4'd2;
      end_session();
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) check_reply(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READY_INTERVAL:   ready_ivl  = cfg_data;
          CFG_SESSION_TIMEOUT:  sess_limit = cfg_data;
          CFG_BYTE_TIMEOUT:     gap_limit  = cfg_data;
          CFG_CANCEL_THRESHOLD: can_limit  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_replies(in_data);
    end
    mismatches      <= errors;
    replies_pending <= replies_due.size();
    replies_seen    <= seen;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the XMODEM-CRC receiver: stimulus, flow control and the verdict.
module tb;
  import xcr_pkg::*;
  import xcr_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  xcr_in_t      in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  xcr_out_t     out_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  xcr_cfg_idx_t cfg_index = CFG_READY_INTERVAL;
  logic [15:0]  cfg_data = '0;

  int           mismatches;
  int           replies_pending;
  int           replies_seen;

  int           beats_sent = 0;
  int           blocks_sent = 0;
  int           settings_used = 0;
  int           idle_cycles = 0;
  int           holds_asked = 0;
  logic         calm = 1'b0;
  logic [7:0]   next_blk = 8'd1;
  logic [3:0]   cancel_at = 4'd2;

  xmodem_crc_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xcr_response_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .replies_pending (replies_pending),
    .replies_seen    (replies_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no beat moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int holds_done;
    int n;
    holds_done = 0;
    forever begin
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_beat(logic op, logic [7:0] b);
    int      gap;
    xcr_in_t beat;
    gap = pick_gap();
    beat.operation = op;
    beat.rx_byte = b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(1'b1, 8'($urandom));
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 99) < 3) send_ticks($urandom_range(1, 3));
  endtask

  // truncated block, left to the byte timer
  task automatic send_stub();
    send_beat(1'b0, CH_SOH);
    repeat ($urandom_range(1, 8)) send_beat(1'b0, 8'($urandom));
    send_ticks($urandom_range(1, 6));
  endtask

  task automatic send_block();
    logic [7:0]  num;
    logic [7:0]  cmp;
    logic [7:0]  d;
    logic [15:0] crc;
    logic        good;
    int          r;
    r = $urandom_range(0, 99);
    num = (r < 70) ? next_blk : (r < 85) ? next_blk - 8'd1 : 8'($urandom);
    cmp = ~num;
    if ($urandom_range(0, 99) < 10) cmp = cmp ^ (8'd1 << $urandom_range(0, 7));
    crc = '0;
    send_beat(1'b0, CH_SOH);
    send_beat(1'b0, num);
    send_beat(1'b0, cmp);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      maybe_ticks();
      d = 8'($urandom);
      crc = crc16_step(crc, d);
      send_beat(1'b0, d);
    end
    good = $urandom_range(0, 99) >= 12;
    if (!good) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    maybe_ticks();
    send_beat(1'b0, crc[15:8]);
    maybe_ticks();
    send_beat(1'b0, crc[7:0]);
    if (good && cmp == ~num && num == next_blk) next_blk = next_blk + 8'd1;
    blocks_sent++;
  endtask

  task automatic random_sequence(int room);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (room >= BLOCK_BYTES + 10) begin
        send_block();
      end else begin
        send_stub();
      end
    end else if (r < 63) begin
      send_beat(1'b0, CH_EOT);
      next_blk = 8'd1;
    end else if (r < 73) begin
      k = $urandom_range(1, 4);
      repeat (k) send_beat(1'b0, CH_CAN);
      if (k >= cancel_at) next_blk = 8'd1;
    end else if (r < 85) begin
      send_ticks($urandom_range(1, 10));
    end else if (r < 93) begin
      repeat ($urandom_range(1, 6)) send_beat(1'($urandom), 8'($urandom));
    end else begin
      send_stub();
    end
  endtask

  task automatic run_random(int budget);
    int start;
    start = beats_sent;
    while (beats_sent - start < budget) random_sequence(budget - (beats_sent - start));
  endtask

  task automatic put_reg(xcr_cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(logic [15:0] ri, logic [15:0] st, logic [15:0] bt, logic [3:0] ct);
    logic [15:0] cv;
    cv = 16'($urandom);
    cv[3:0] = ct;
    put_reg(CFG_READY_INTERVAL, ri);
    put_reg(CFG_SESSION_TIMEOUT, st);
    put_reg(CFG_BYTE_TIMEOUT, bt);
    put_reg(CFG_CANCEL_THRESHOLD, cv);
    cfg_valid <= 1'b0;
    cancel_at = ct;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_regs(16'd3, 16'd6, 16'd2, 4'd2);
    send_ticks(3);
    send_beat(1'b0, 8'h55);
    send_beat(1'b0, CH_CAN);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, CH_CAN);
    send_beat(1'b0, CH_CAN);
    send_beat(1'b0, CH_EOT);
    send_beat(1'b0, CH_SOH);
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, 8'hFE);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_ticks(3);
    send_beat(1'b0, CH_CAN);
    send_beat(1'b0, CH_CAN);
    send_beat(1'b0, CH_SOH);
    send_ticks(6);
    drain();
    next_blk = 8'd1;

    write_regs(16'd5, 16'd40, 16'd3, 4'd3);
    run_random(8);
    // stall the receiver while the sender streams a block back to back
    calm = 1'b1;
    holds_asked++;
    send_block();
    calm = 1'b0;
    run_random(8);
    drain();

    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    run_random(8);
    drain();

    write_regs(16'd0, 16'd0, 16'd1, 4'd0);
    run_random(8);
    drain();
    next_blk = 8'd1;

    write_regs(16'd1, 16'd200, 16'd1, 4'd1);
    run_random(10);
    drain();

    $display("Sent %0d input beats, %0d framed blocks, under %0d register settings;",
             beats_sent, blocks_sent, settings_used);
    $display("checked %0d result beats with %0d mismatches.", replies_seen, mismatches);
    if (mismatches == 0 && replies_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/xcr_pkg.sv
hw/rtl/xcr_core.sv
hw/rtl/xcr_out_queue.sv
hw/rtl/xmodem_crc_receiver.sv
tb/sv/xcr_response_checker.sv
tb/sv/tb.sv
